// File: hdl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; every other file imports this package.
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;   // width of the carried input field
   localparam int CHAR_BITS   = 6;    // width of one output character
   localparam int DIGIT_DEPTH = 10;   // decimal digits held in the BCD register
   localparam int DIGIT_BITS  = 4;
   localparam int BCD_BITS    = DIGIT_DEPTH * DIGIT_BITS;
   localparam int IDX_BITS    = 4;    // selects one of DIGIT_DEPTH digits

   localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = 6'd45;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 6'd48;
   localparam logic [DIGIT_BITS-1:0] BCD_LIMIT  = 4'd5;   // add-3 threshold
   localparam logic [DIGIT_BITS-1:0] BCD_ADJUST = 4'd3;
   localparam logic [DIGIT_BITS-1:0] RADIX      = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_FIND,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;         // take the input value, clear the BCD register
      logic shift;        // one double-dabble step
      logic find;         // point at the most significant nonzero digit
      logic load_sign;    // put '-' into the output register
      logic load_digit;   // put the pointed digit into the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic negative;
      logic ptr_zero;     // pointed digit is the least significant one
      logic out_free;     // output register can take a character this cycle
   } dp_status_type;

endpackage

// File: hdl/itoa_req_if.sv
// Input channel: one signed integer per transfer.
// Depends on itoa_pkg.
interface itoa_req_if import itoa_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// File: hdl/itoa_rsp_if.sv
// Result channel: one ASCII character per transfer, last marks the end of a number.
// Depends on itoa_pkg.
interface itoa_rsp_if import itoa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ascii_char;
   logic                 last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// File: hdl/itoa_ctrl.sv
// Sequencer for the converter: state machine and shift-step counter.
// Depends on itoa_pkg; drives itoa_dp through dp_cmd_type.
module itoa_ctrl import itoa_pkg::*; #(
   parameter int MAG_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(MAG_BITS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SHIFT;
         ST_SHIFT: if (cnt_ff == '0) state_in = ST_FIND;
         ST_FIND:  state_in = status.negative ? ST_SIGN : ST_EMIT;
         ST_SIGN:  if (status.out_free) state_in = ST_EMIT;
         ST_EMIT:  if (status.out_free && status.ptr_zero) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and step counter
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_BITS'(MAG_BITS - 1);
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff - 1'b1;
         end
         ST_FIND: cmd.find       = 1'b1;
         ST_SIGN: cmd.load_sign  = status.out_free;
         ST_EMIT: cmd.load_digit = status.out_free;
         default: cmd = '0;
      endcase
   end

   a_accept_starts_shift: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SHIFT && cnt_ff == CNT_BITS'(MAG_BITS - 1)))
      else $error("accepted item did not start the shift sequence");

   a_last_step_to_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && cnt_ff == '0) |=> (state_ff == ST_FIND))
      else $error("shift sequence did not end after the last step");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_sign || cmd.load_digit) |-> status.out_free)
      else $error("character loaded while output register occupied");

endmodule

// File: hdl/itoa_dp.sv
// Datapath: magnitude, double-dabble BCD register, digit pointer, output register.
// Depends on itoa_pkg; steered by itoa_ctrl through dp_cmd_type.
module itoa_dp import itoa_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [VALUE_WIDTH-1:0] value,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [CHAR_BITS-1:0]          ascii_char,
   output logic                          last
);

   localparam int MAG_BITS = (VALUE_BITS > VALUE_WIDTH) ? VALUE_WIDTH : VALUE_BITS;
   localparam bit HAS_SIGN = (VALUE_BITS <= VALUE_WIDTH);

   logic [MAG_BITS-1:0]  mag_ff, mag_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic [IDX_BITS-1:0]  ptr_ff, ptr_in;
   logic                 neg_ff, neg_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic                 last_ff, last_in;

   logic [MAG_BITS-1:0]   raw;
   logic                  raw_neg;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [DIGIT_BITS-1:0] cur_digit;
   logic                  out_free;

   // Index of the most significant nonzero digit, zero when all are zero
   function automatic logic [IDX_BITS-1:0] top_digit(input logic [BCD_BITS-1:0] bcd);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         if (bcd[i*DIGIT_BITS +: DIGIT_BITS] != '0) idx = IDX_BITS'(i);
      end
      return idx;
   endfunction

   assign raw     = value[MAG_BITS-1:0];
   assign raw_neg = HAS_SIGN && raw[MAG_BITS-1];

   // Add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
            (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= BCD_LIMIT) ?
            bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + BCD_ADJUST :
            bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
      end
   end

   assign cur_digit = bcd_ff[ptr_ff*DIGIT_BITS +: DIGIT_BITS];
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      ptr_in  = ptr_ff;
      neg_in  = neg_ff;
      char_in = char_ff;
      last_in = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load) begin
         neg_in = raw_neg;
         mag_in = raw_neg ? MAG_BITS'(~raw + 1'b1) : raw;
         bcd_in = '0;
      end
      if (cmd.shift) begin
         bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[MAG_BITS-1]};
         mag_in = {mag_ff[MAG_BITS-2:0], 1'b0};
      end
      if (cmd.find) ptr_in = top_digit(bcd_ff);
      if (cmd.load_sign) begin
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
         out_valid_in = 1'b1;
      end
      if (cmd.load_digit) begin
         char_in      = CHAR_ZERO + CHAR_BITS'(cur_digit);
         last_in      = (ptr_ff == '0);
         out_valid_in = 1'b1;
         if (ptr_ff != '0) ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      ptr_ff  <= ptr_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.negative = neg_ff;
   assign status.ptr_zero = (ptr_ff == '0);
   assign status.out_free = out_free;

   assign rsp_valid  = out_valid_ff;
   assign ascii_char = char_ff;
   assign last       = last_ff;

   a_digit_is_decimal: assert property (@(posedge clock) disable iff (reset)
      cmd.load_digit |-> (cur_digit < RADIX))
      else $error("BCD digit out of range at emission");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sign |-> neg_ff)
      else $error("minus sign emitted for a non-negative value");

   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(ascii_char) && $stable(last)))
      else $error("output character changed before the sink took it");

endmodule

// File: hdl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on itoa_pkg, itoa_req_if, itoa_rsp_if, itoa_ctrl and itoa_dp.
//
// Takes one signed integer per req_ch transfer and returns its decimal text on rsp_ch,
// one ASCII character per transfer: a '-' first for negative values, then the digits
// most significant first without leading zeros, with last set on the final character.
// Zero gives "0"; the most negative value prints its full magnitude 2^(VALUE_BITS-1).
// Only the low VALUE_BITS bits of value count, and bit VALUE_BITS-1 is the sign; with
// VALUE_BITS above 32 every value reads as unsigned. An item passes through acceptance,
// M = min(VALUE_BITS, 32) steps of shift-and-add-3 in the BCD register, a search for
// the leading digit, and then the characters, one per cycle when the sink takes them
// at once. The next item is
// accepted as soon as the last character sits in the output register.
module signed_int_to_decimal_ascii_top import itoa_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   itoa_req_if.sink    req_ch,
   itoa_rsp_if.source  rsp_ch
);

   // Number of shift steps: the magnitude never needs more than the carried field
   localparam int MAG_BITS = (VALUE_BITS > VALUE_WIDTH) ? VALUE_WIDTH : VALUE_BITS;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: accepts a transfer in idle, counts the shift steps, then paces the
   // sign and digits into the output register whenever that register frees up.
   itoa_ctrl #(
      .MAG_BITS (MAG_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: magnitude, BCD register, digit pointer and the output register that
   // holds a character until the sink takes it.
   itoa_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_ch.value),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .ascii_char (rsp_ch.ascii_char),
      .last       (rsp_ch.last)
   );

endmodule
